FILE: hdl/c8eu_pkg.sv
package c8eu_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STACK_DW    = $clog2(STACK_DEPTH + 1);
  localparam int NUM_REGS    = 16;
  localparam int REG_AW      = $clog2(NUM_REGS);

  localparam logic [REG_AW-1:0] FLAG_REG = REG_AW'(NUM_REGS - 1);
  localparam logic [11:0]       PC_START = 12'd512;
  localparam logic [11:0]       PC_SKIP  = 12'd2;

  localparam logic [4:0] OP_LD    = 5'd0;
  localparam logic [4:0] OP_OR    = 5'd1;
  localparam logic [4:0] OP_XOR   = 5'd2;
  localparam logic [4:0] OP_AND   = 5'd3;
  localparam logic [4:0] OP_ADD   = 5'd4;
  localparam logic [4:0] OP_SUB   = 5'd5;
  localparam logic [4:0] OP_SHR   = 5'd6;
  localparam logic [4:0] OP_SHL   = 5'd7;
  localparam logic [4:0] OP_SE    = 5'd8;
  localparam logic [4:0] OP_SNE   = 5'd9;
  localparam logic [4:0] OP_JP    = 5'd10;
  localparam logic [4:0] OP_CALL  = 5'd11;
  localparam logic [4:0] OP_RET   = 5'd12;
  localparam logic [4:0] OP_LDI   = 5'd13;
  localparam logic [4:0] OP_ADDI  = 5'd14;
  localparam logic [4:0] OP_RD_DT = 5'd15;
  localparam logic [4:0] OP_WR_DT = 5'd16;
  localparam logic [4:0] OP_WR_ST = 5'd17;

  typedef struct packed {
    logic [4:0]        op;
    logic [REG_AW-1:0] reg_index;
    logic [7:0]        value;
    logic [7:0]        value_two;
    logic [11:0]       target_address;
  } item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [7:0]  reg_result;
    logic [7:0]  flag_reg;
    logic [15:0] index_value;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic        stack_error;
  } result_t;

endpackage

FILE: hdl/c8eu_ram.sv
module c8eu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/chip8_register_execute_unit.sv
// Items are registered into the execute stage; results go to a 3-entry result queue.
// Throughput: one item per cycle unless stalled; the register file and the return stack
//   are synchronous RAMs read at transfer and written back next cycle, with forwarding.
// Reset (rst, synchronous): V0..VF, index, timers and stack depth to 0, pc to 512;
//   V0..VE read as 0 through per-register written flags until first written.
//   Return stack contents are left as they are. No clearing pass.
module chip8_register_execute_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  c8eu_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output c8eu_pkg::result_t result
);
  import c8eu_pkg::*;

  localparam int QDEPTH = 3;
  localparam logic [STACK_DW-1:0] STACK_FULL = STACK_DW'(STACK_DEPTH);

  // execute stage
  logic        s1_valid;
  item_t       s1;

  // architectural state outside the RAMs
  logic [11:0]         pc;
  logic [15:0]         index_reg;
  logic [7:0]          delay_t;
  logic [7:0]          sound_t;
  logic [7:0]          vf;
  logic [STACK_DW-1:0] depth;
  logic [NUM_REGS-1:0] gp_vld;

  logic [11:0]         pc_next;
  logic [15:0]         index_next;
  logic [7:0]          delay_next;
  logic [7:0]          sound_next;
  logic [7:0]          vf_next;
  logic [STACK_DW-1:0] depth_next;

  // forwarding of the write made at the same edge as the RAM read
  logic                gp_fwd_en;
  logic [REG_AW-1:0]   gp_fwd_addr;
  logic [7:0]          gp_fwd_data;
  logic                stk_fwd_en;
  logic [STACK_AW-1:0] stk_fwd_addr;
  logic [11:0]         stk_fwd_data;

  logic [7:0]          gp_rdata;
  logic [11:0]         stk_rdata;

  logic                accept;
  logic [7:0]          rx;
  logic [11:0]         stk_top;
  logic [STACK_DW-1:0] depth_m1;
  logic [STACK_DW-1:0] rd_depth;
  logic [7:0]          res;
  logic                wr_x;
  logic                flag_wr;
  logic                flag_val;
  logic                push;
  logic                err;
  logic [8:0]          sum9;
  logic                gp_we;
  result_t             s1_result;

  // result queue
  result_t     q [QDEPTH];
  logic [1:0]  q_wr;
  logic [1:0]  q_rd;
  logic [1:0]  q_count;
  logic [2:0]  in_flight;
  logic        q_pop;

  assign in_flight  = {1'b0, q_count} + {2'b00, s1_valid};
  assign item_stall = (in_flight >= 3'(QDEPTH));
  assign accept     = item_valid && !item_stall;

  assign depth_m1 = depth - 1'b1;
  assign rd_depth = depth_next - 1'b1;

  // a register never written since reset reads as zero
  assign rx = (s1.reg_index == FLAG_REG) ? vf :
              (gp_fwd_en && gp_fwd_addr == s1.reg_index) ? gp_fwd_data :
              gp_vld[s1.reg_index] ? gp_rdata : 8'h00;
  assign stk_top = (stk_fwd_en && stk_fwd_addr == depth_m1[STACK_AW-1:0]) ?
                   stk_fwd_data : stk_rdata;
  assign sum9 = {1'b0, rx} + {1'b0, s1.value};

  always_comb begin
    pc_next    = pc;
    index_next = index_reg;
    delay_next = delay_t;
    sound_next = sound_t;
    depth_next = depth;
    res        = rx;
    wr_x       = 1'b0;
    flag_wr    = 1'b0;
    flag_val   = 1'b0;
    push       = 1'b0;
    err        = 1'b0;
    if (s1_valid) begin
      unique case (s1.op)
        OP_LD:  begin res = s1.value;       wr_x = 1'b1; end
        OP_OR:  begin res = rx | s1.value;  wr_x = 1'b1; end
        OP_XOR: begin res = rx ^ s1.value;  wr_x = 1'b1; end
        OP_AND: begin res = rx & s1.value;  wr_x = 1'b1; end
        OP_ADD: begin
          res      = sum9[7:0];
          wr_x     = 1'b1;
          flag_wr  = 1'b1;
          flag_val = sum9[8];
        end
        OP_SUB: begin
          res      = rx - s1.value;
          wr_x     = 1'b1;
          flag_wr  = 1'b1;
          flag_val = (rx >= s1.value);
        end
        OP_SHR: begin
          res      = {1'b0, rx[7:1]};
          wr_x     = 1'b1;
          flag_wr  = 1'b1;
          flag_val = rx[0];
        end
        OP_SHL: begin
          res      = {rx[6:0], 1'b0};
          wr_x     = 1'b1;
          flag_wr  = 1'b1;
          flag_val = rx[7];
        end
        OP_SE: begin
          if (s1.value == s1.value_two) begin
            pc_next = pc + PC_SKIP;
          end
        end
        OP_SNE: begin
          if (s1.value != s1.value_two) begin
            pc_next = pc + PC_SKIP;
          end
        end
        OP_JP:  pc_next = s1.target_address;
        OP_CALL: begin
          if (depth >= STACK_FULL) begin
            err = 1'b1;
          end else begin
            push       = 1'b1;
            depth_next = depth + 1'b1;
            pc_next    = s1.target_address;
          end
        end
        OP_RET: begin
          if (depth == '0) begin
            err = 1'b1;
          end else begin
            depth_next = depth_m1;
            pc_next    = stk_top;
          end
        end
        OP_LDI:   index_next = {4'b0000, s1.target_address};
        OP_ADDI:  index_next = index_reg + {8'b0, rx};
        OP_RD_DT: begin res = delay_t; wr_x = 1'b1; end
        OP_WR_DT: delay_next = rx;
        OP_WR_ST: sound_next = s1.value;
        default: ;
      endcase
    end

    // flag write lands after the Vx write
    vf_next = vf;
    if (wr_x && s1.reg_index == FLAG_REG) begin
      vf_next = res;
    end
    if (flag_wr) begin
      vf_next = {7'b0, flag_val};
    end
  end

  assign gp_we = s1_valid && wr_x && (s1.reg_index != FLAG_REG);

  always_comb begin
    s1_result.program_counter = pc_next;
    s1_result.reg_result      = (s1.reg_index == FLAG_REG) ? vf_next : (wr_x ? res : rx);
    s1_result.flag_reg        = vf_next;
    s1_result.index_value     = index_next;
    s1_result.delay_value     = delay_next;
    s1_result.sound_value     = sound_next;
    s1_result.stack_error     = err;
  end

  c8eu_ram #(
    .WIDTH (8),
    .DEPTH (NUM_REGS)
  ) u_gp_ram (
    .clk   (clk),
    .we    (gp_we),
    .waddr (s1.reg_index),
    .wdata (res),
    .re    (accept),
    .raddr (item.reg_index),
    .rdata (gp_rdata)
  );

  c8eu_ram #(
    .WIDTH (12),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push),
    .waddr (depth[STACK_AW-1:0]),
    .wdata (pc),
    .re    (accept),
    .raddr (rd_depth[STACK_AW-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pc         <= PC_START;
      index_reg  <= '0;
      delay_t    <= '0;
      sound_t    <= '0;
      vf         <= '0;
      depth      <= '0;
      gp_vld     <= '0;
      gp_fwd_en  <= 1'b0;
      stk_fwd_en <= 1'b0;
    end else begin
      s1_valid   <= accept;
      pc         <= pc_next;
      index_reg  <= index_next;
      delay_t    <= delay_next;
      sound_t    <= sound_next;
      vf         <= vf_next;
      depth      <= depth_next;
      if (gp_we) begin
        gp_vld[s1.reg_index] <= 1'b1;
      end
      gp_fwd_en  <= gp_we;
      stk_fwd_en <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
    gp_fwd_addr  <= s1.reg_index;
    gp_fwd_data  <= res;
    stk_fwd_addr <= depth[STACK_AW-1:0];
    stk_fwd_data <= pc;
  end

  // result queue
  assign result_valid = (q_count != 2'd0);
  assign result       = q[q_rd];
  assign q_pop        = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_wr <= (q_wr == 2'(QDEPTH - 1)) ? 2'd0 : q_wr + 2'd1;
      end
      if (q_pop) begin
        q_rd <= (q_rd == 2'(QDEPTH - 1)) ? 2'd0 : q_rd + 2'd1;
      end
      q_count <= q_count + {1'b0, s1_valid} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q[q_wr] <= s1_result;
    end
  end

endmodule

FILE: hdl/c8eu_checker.sv
module c8eu_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input c8eu_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input c8eu_pkg::result_t result
);
  import c8eu_pkg::*;

  // nothing in flight right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("result pending or input stalled after reset");

  // a lone transfer into an empty block shows a result once it has passed the execute stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && !result_valid) ##1 !item_valid |=> result_valid)
    else $error("result missing two cycles after transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> $past(!result_stall))
    else $error("result withdrawn without transfer");

endmodule

bind chip8_register_execute_unit c8eu_checker u_c8eu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
